### rtl/core/aism_pkg.sv
// Shared types and constants of the independent-set annealing move core.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package aism_pkg;

    localparam int NUM_VERTICES = 64;
    localparam int VERTEX_BITS  = 6;
    localparam int WEIGHT_BITS  = 16;
    localparam int COST_BITS    = 22;
    localparam int COUNT_BITS   = 7;
    localparam int TEMP_BITS    = 16;
    localparam int SER_TERMS    = 16;   // series terms after the constant one
    localparam int XQ_BITS      = 36;   // quotient bits of d * 2^32 / T
    localparam int DIV_STEPS    = 4;    // bytes per 32-bit term divided by k

    localparam logic [2:0] ACT_LOAD  = 3'd0;
    localparam logic [2:0] ACT_EDGE  = 3'd1;
    localparam logic [2:0] ACT_MOVE  = 3'd2;
    localparam logic [2:0] ACT_FLIP  = 3'd3;
    localparam logic [2:0] ACT_CLEAR = 3'd4;

    typedef enum logic [2:0] {
        K_NONE,
        K_LOAD,
        K_EDGE,
        K_MOVE,
        K_CLEAR
    } kind_t;

    typedef enum logic [1:0] {
        MUL_SER,
        MUL_SQ,
        MUL_POW
    } mul_sel_t;

    typedef struct packed {
        logic     take;
        logic     load_wr;
        logic     edge_u;
        logic     edge_v;
        logic     capture;
        logic     clear;
        logic     walk;
        logic     div_init;
        logic     div_step;
        logic     ser_init;
        logic     half_init;
        logic     mul;
        mul_sel_t mul_sel;
        logic     ser_fix;
        logic     sdiv;
        logic     ser_acc;
        logic     ser_end;
        logic     e1_fix;
        logic     pow_fix;
        logic     apply;
        logic     finish;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  sel_u;
        logic  walk_last;
        logic  win_now;
        logic  exp_zero;
        logic  div_last;
        logic  sdiv_last;
        logic  ser_last;
        logic  ser_mode;
        logic  n_zero;
        logic  n_one;
        logic  exp_win;
        logic  out_free;
    } sts_t;

endpackage

`default_nettype wire

### rtl/core/aism_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module aism_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### rtl/core/aism_dp.sv
// Datapath: selection, costs, weight and adjacency RAMs, neighbour walk,
// long divider, series unit and shared multiplier. Uses aism_pkg, aism_ram.
`timescale 1ns / 1ps
`default_nettype none

module aism_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire aism_pkg::cmd_t                cmd,
    output aism_pkg::sts_t                     sts,
    input  wire logic [63:0]                   s_tdata,
    input  wire logic [2:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [47:0]                        m_tdata,
    input  wire logic                          cfg_wen,
    input  wire logic [aism_pkg::COUNT_BITS-1:0] cfg_wdata
);
    import aism_pkg::*;

    // latched word
    logic [2:0]             act_reg;
    logic [VERTEX_BITS-1:0] u_reg, v_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic [TEMP_BITS-1:0]   t_reg, rnd_reg;

    logic [COUNT_BITS-1:0]   vcount_reg;
    logic [NUM_VERTICES-1:0] sel_reg, row_vld_reg, row_u_reg;
    logic [COST_BITS-1:0]    cost_reg, best_reg, add_reg, sub_reg;
    logic                    acc_reg, rvld_reg;
    logic [COUNT_BITS-1:0]   j_reg;
    logic                    mask_d_reg, vld_d_reg;

    logic [TEMP_BITS-1:0] drem_reg;
    logic [XQ_BITS-1:0]   dq_reg;
    logic [5:0]           dcnt_reg;

    logic [31:0] f_reg, sdq_reg, e1_reg;
    logic [3:0]  n_reg, srem_reg;
    logic [32:0] term_reg, r_reg;
    logic [33:0] pos_reg, neg_reg;
    logic [4:0]  k_reg;
    logic [1:0]  scnt_reg;
    logic        mode_reg;
    logic [63:0] prod_reg;

    logic                    m_valid_reg;
    logic [47:0]             m_data_reg;

    logic [WEIGHT_BITS-1:0]  w_rd;
    logic [NUM_VERTICES-1:0] row_rd, row_q, row_wdata;
    logic [VERTEX_BITS-1:0]  w_raddr, row_raddr, row_waddr, bit_idx;
    logic [COUNT_BITS-1:0]   lim;
    logic                    u_ok, v_ok;
    logic [COST_BITS-1:0]    d, best_n;
    logic [31:0]             mul_a, mul_b, fix_prod;
    logic [16:0]             drem_t;
    logic                    div_ge;
    logic [33:0]             ser_sum;

    assign row_q = rvld_reg ? row_rd : '0;

    aism_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(NUM_VERTICES)) u_wram (
        .aclk   (aclk),
        .wr_en  (cmd.load_wr),
        .wr_addr(u_reg),
        .wr_data(w_reg),
        .rd_addr(w_raddr),
        .rd_data(w_rd)
    );

    aism_ram #(.WIDTH(NUM_VERTICES), .DEPTH(NUM_VERTICES)) u_aram (
        .aclk   (aclk),
        .wr_en  (cmd.edge_u | cmd.edge_v),
        .wr_addr(row_waddr),
        .wr_data(row_wdata),
        .rd_addr(row_raddr),
        .rd_data(row_rd)
    );

    assign w_raddr   = cmd.walk ? j_reg[VERTEX_BITS-1:0] : u_reg;
    assign row_raddr = cmd.edge_u ? v_reg : u_reg;
    assign row_waddr = cmd.edge_v ? v_reg : u_reg;
    assign bit_idx   = cmd.edge_v ? u_reg : v_reg;
    assign row_wdata = row_q | (NUM_VERTICES'(1) << bit_idx);

    // byte of a term divided by a small k, one restoring step per bit
    function automatic logic [11:0] sdiv_byte(input logic [3:0] rem, input logic [7:0] num,
                                              input logic [4:0] k);
        logic [4:0] t;
        logic [3:0] r;
        logic [7:0] q;
        r = rem;
        q = '0;
        for (int i = 7; i >= 0; i--) begin
            t = {r, num[i]};
            if (t >= k) begin
                r = 4'(t - k);
                q[i] = 1'b1;
            end else begin
                r = t[3:0];
            end
        end
        return {r, q};
    endfunction

    logic [11:0] sdiv_out;
    assign sdiv_out = sdiv_byte(srem_reg, sdq_reg[31:24], k_reg);

    always_comb begin
        lim  = (vcount_reg > COUNT_BITS'(NUM_VERTICES)) ? COUNT_BITS'(NUM_VERTICES) : vcount_reg;
        u_ok = {1'b0, u_reg} < lim;
        v_ok = {1'b0, v_reg} < lim;
        d    = sub_reg - add_reg;
        case (act_reg)
            ACT_LOAD:  sts.kind = u_ok ? K_LOAD : K_NONE;
            ACT_EDGE:  sts.kind = (u_ok && v_ok && u_reg != v_reg) ? K_EDGE : K_NONE;
            ACT_MOVE:  sts.kind = u_ok ? K_MOVE : K_NONE;
            ACT_FLIP:  sts.kind = u_ok ? K_MOVE : K_NONE;
            ACT_CLEAR: sts.kind = K_CLEAR;
            default:   sts.kind = K_NONE;
        endcase
        sts.sel_u     = sel_reg[u_reg];
        sts.walk_last = j_reg == COUNT_BITS'(NUM_VERTICES);
        sts.win_now   = act_reg == ACT_FLIP || add_reg >= sub_reg;
        sts.exp_zero  = d >= COST_BITS'(t_reg) * COST_BITS'(12);
        sts.div_last  = dcnt_reg == 6'(XQ_BITS - 1);
        sts.sdiv_last = scnt_reg == 2'(DIV_STEPS - 1);
        sts.ser_last  = k_reg == 5'(SER_TERMS);
        sts.ser_mode  = mode_reg;
        sts.n_zero    = n_reg == 4'd0;
        sts.n_one     = n_reg == 4'd1;
        sts.exp_win   = r_reg[32:16] > {1'b0, rnd_reg};
        sts.out_free  = !m_valid_reg || m_tready;

        case (cmd.mul_sel)
            MUL_SER: begin
                mul_a = term_reg[31:0];
                mul_b = f_reg;
            end
            MUL_SQ: begin
                mul_a = e1_reg;
                mul_b = e1_reg;
            end
            MUL_POW: begin
                mul_a = r_reg[31:0];
                mul_b = e1_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        // a top bit set means the operand is exactly 2^32
        fix_prod = prod_reg[63:32] + (term_reg[32] ? f_reg : 32'd0);

        drem_t = {drem_reg, dq_reg[XQ_BITS-1]};
        div_ge = drem_t >= {1'b0, t_reg};
        ser_sum = pos_reg - neg_reg;
        best_n = (cost_reg > best_reg) ? cost_reg : best_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg  <= COUNT_BITS'(NUM_VERTICES);
            sel_reg     <= '0;
            row_vld_reg <= '0;
            cost_reg    <= '0;
            best_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                vcount_reg <= cfg_wdata;
            end
            if (cmd.edge_u) begin
                row_vld_reg[u_reg] <= 1'b1;
            end
            if (cmd.edge_v) begin
                row_vld_reg[v_reg] <= 1'b1;
            end
            if (cmd.load_wr && sel_reg[u_reg]) begin
                cost_reg <= cost_reg - COST_BITS'(w_rd) + COST_BITS'(w_reg);
            end
            if (cmd.clear) begin
                sel_reg  <= '0;
                cost_reg <= '0;
                best_reg <= '0;
            end
            if (cmd.apply) begin
                if (sel_reg[u_reg]) begin
                    sel_reg[u_reg] <= 1'b0;
                end else begin
                    sel_reg <= (sel_reg & ~row_u_reg) | (NUM_VERTICES'(1) << u_reg);
                end
                cost_reg <= cost_reg - sub_reg + add_reg;
            end
            if (cmd.finish) begin
                best_reg    <= best_n;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rvld_reg <= row_vld_reg[row_raddr];
        if (cmd.take) begin
            act_reg <= s_tuser;
            u_reg   <= s_tdata[5:0];
            v_reg   <= s_tdata[11:6];
            w_reg   <= s_tdata[27:12];
            t_reg   <= s_tdata[43:28];
            rnd_reg <= s_tdata[59:44];
            acc_reg <= 1'b0;
        end
        if (cmd.apply) begin
            acc_reg <= 1'b1;
        end
        if (cmd.capture) begin
            row_u_reg  <= row_q;
            j_reg      <= '0;
            vld_d_reg  <= 1'b0;
            mask_d_reg <= 1'b0;
            if (sel_reg[u_reg]) begin
                sub_reg <= COST_BITS'(w_rd);
                add_reg <= '0;
            end else begin
                add_reg <= COST_BITS'(w_rd);
                sub_reg <= '0;
            end
        end
        // weight of vertex j arrives in the cycle after its address
        if (cmd.walk) begin
            if (vld_d_reg && mask_d_reg) begin
                sub_reg <= sub_reg + COST_BITS'(w_rd);
            end
            vld_d_reg  <= !j_reg[COUNT_BITS-1];
            mask_d_reg <= row_u_reg[j_reg[VERTEX_BITS-1:0]] &
                          sel_reg[j_reg[VERTEX_BITS-1:0]] &
                          (j_reg[VERTEX_BITS-1:0] != u_reg);
            j_reg      <= j_reg + 1'b1;
        end
        // d < 16T, so d >> 4 is already a valid partial remainder
        if (cmd.div_init) begin
            drem_reg <= d[19:4];
            dq_reg   <= {d[3:0], 32'd0};
            dcnt_reg <= '0;
        end
        if (cmd.div_step) begin
            drem_reg <= div_ge ? TEMP_BITS'(drem_t - {1'b0, t_reg}) : drem_t[TEMP_BITS-1:0];
            dq_reg   <= {dq_reg[XQ_BITS-2:0], div_ge};
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.ser_init || cmd.half_init) begin
            term_reg <= 33'h1_0000_0000;
            pos_reg  <= 34'h1_0000_0000;
            neg_reg  <= '0;
            k_reg    <= 5'd1;
        end
        if (cmd.ser_init) begin
            f_reg    <= dq_reg[31:0];
            n_reg    <= dq_reg[XQ_BITS-1:32];
            mode_reg <= 1'b0;
        end
        if (cmd.half_init) begin
            f_reg    <= 32'h8000_0000;
            mode_reg <= 1'b1;
        end
        if (cmd.mul) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.ser_fix) begin
            sdq_reg  <= fix_prod;
            srem_reg <= '0;
            scnt_reg <= '0;
        end
        if (cmd.sdiv) begin
            sdq_reg  <= {sdq_reg[23:0], sdiv_out[7:0]};
            srem_reg <= sdiv_out[11:8];
            scnt_reg <= scnt_reg + 1'b1;
        end
        if (cmd.ser_acc) begin
            term_reg <= {1'b0, sdq_reg};
            if (k_reg[0]) begin
                neg_reg <= neg_reg + 34'(sdq_reg);
            end else begin
                pos_reg <= pos_reg + 34'(sdq_reg);
            end
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.ser_end) begin
            if (mode_reg) begin
                e1_reg <= ser_sum[31:0];
            end else begin
                r_reg <= ser_sum[32:0];
            end
        end
        if (cmd.e1_fix) begin
            e1_reg <= prod_reg[63:32];
        end
        if (cmd.pow_fix) begin
            r_reg <= {1'b0, prod_reg[63:32] + (r_reg[32] ? e1_reg : 32'd0)};
            n_reg <= n_reg - 1'b1;
        end
        if (cmd.finish) begin
            m_data_reg <= {3'd0, best_n, cost_reg, acc_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

### rtl/core/aism_ctrl.sv
// Controller state machine: sequences reads, walk, divider, series and result.
// Uses aism_pkg; drives the datapath commands.
`timescale 1ns / 1ps
`default_nettype none

module aism_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire aism_pkg::sts_t sts,
    output aism_pkg::cmd_t      cmd
);
    import aism_pkg::*;

    typedef enum logic [22:0] {
        S_IDLE    = 23'd1 << 0,
        S_RD      = 23'd1 << 1,
        S_LOAD_WR = 23'd1 << 2,
        S_EDGE_U  = 23'd1 << 3,
        S_EDGE_V  = 23'd1 << 4,
        S_CAPT    = 23'd1 << 5,
        S_WALK    = 23'd1 << 6,
        S_DECIDE  = 23'd1 << 7,
        S_DIV     = 23'd1 << 8,
        S_SINIT   = 23'd1 << 9,
        S_SMUL    = 23'd1 << 10,
        S_SFIX    = 23'd1 << 11,
        S_SDIV    = 23'd1 << 12,
        S_SACC    = 23'd1 << 13,
        S_SEND    = 23'd1 << 14,
        S_HINIT   = 23'd1 << 15,
        S_EMUL    = 23'd1 << 16,
        S_EFIX    = 23'd1 << 17,
        S_PMUL    = 23'd1 << 18,
        S_PFIX    = 23'd1 << 19,
        S_CMP     = 23'd1 << 20,
        S_APPLY   = 23'd1 << 21,
        S_DONE    = 23'd1 << 22
    } state_t;

    state_t state_reg, state_next;

    // no word is taken while reset is held
    assign s_tready = aresetn && state_reg == S_IDLE;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_SER;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                case (sts.kind)
                    K_LOAD:  state_next = S_LOAD_WR;
                    K_EDGE:  state_next = S_EDGE_U;
                    K_MOVE:  state_next = S_CAPT;
                    K_CLEAR: begin
                        cmd.clear  = 1'b1;
                        state_next = S_DONE;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_LOAD_WR: begin
                cmd.load_wr = 1'b1;
                state_next  = S_DONE;
            end
            S_EDGE_U: begin
                cmd.edge_u = 1'b1;
                state_next = S_EDGE_V;
            end
            S_EDGE_V: begin
                cmd.edge_v = 1'b1;
                state_next = S_DONE;
            end
            S_CAPT: begin
                cmd.capture = 1'b1;
                state_next  = sts.sel_u ? S_DECIDE : S_WALK;
            end
            S_WALK: begin
                cmd.walk = 1'b1;
                if (sts.walk_last) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (sts.win_now) begin
                    state_next = S_APPLY;
                end else if (sts.exp_zero) begin
                    state_next = S_DONE;
                end else begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_SINIT;
                end
            end
            S_SINIT: begin
                cmd.ser_init = 1'b1;
                state_next   = S_SMUL;
            end
            S_SMUL: begin
                cmd.mul    = 1'b1;
                state_next = S_SFIX;
            end
            S_SFIX: begin
                cmd.ser_fix = 1'b1;
                state_next  = S_SDIV;
            end
            S_SDIV: begin
                cmd.sdiv = 1'b1;
                if (sts.sdiv_last) begin
                    state_next = S_SACC;
                end
            end
            S_SACC: begin
                cmd.ser_acc = 1'b1;
                state_next  = sts.ser_last ? S_SEND : S_SMUL;
            end
            S_SEND: begin
                cmd.ser_end = 1'b1;
                if (sts.ser_mode) begin
                    state_next = S_EMUL;
                end else begin
                    state_next = sts.n_zero ? S_CMP : S_HINIT;
                end
            end
            S_HINIT: begin
                cmd.half_init = 1'b1;
                state_next    = S_SMUL;
            end
            S_EMUL: begin
                cmd.mul     = 1'b1;
                cmd.mul_sel = MUL_SQ;
                state_next  = S_EFIX;
            end
            S_EFIX: begin
                cmd.e1_fix = 1'b1;
                state_next = S_PMUL;
            end
            S_PMUL: begin
                cmd.mul     = 1'b1;
                cmd.mul_sel = MUL_POW;
                state_next  = S_PFIX;
            end
            S_PFIX: begin
                cmd.pow_fix = 1'b1;
                state_next  = sts.n_one ? S_CMP : S_PMUL;
            end
            S_CMP: begin
                state_next = sts.exp_win ? S_APPLY : S_DONE;
            end
            S_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/annealing_independent_set_move_core.sv
// Top level of the independent-set annealing move core.
// Uses aism_pkg, aism_ctrl and aism_dp (which holds the aism_ram instances).
//
//  channel  dir  handshake           payload
//  s_       in   s_tvalid/s_tready   s_tuser action; s_tdata vertex..random_value
//  m_       out  m_tvalid/m_tready   m_tdata accepted, run_cost, best_cost
//  cfg_     in   cfg_wen             cfg_wdata vertex_count
//
// Clear and ignored words pass the read state only; a load adds a write, an added edge two.
// A move of an unselected vertex adds a walk over all vertices, and an applied move an apply
// step; a lost move adds the long divider and a series of 16 terms, then another series and
// a squaring for e^-1 when the loss is a whole temperature or more, and one multiply per
// whole temperature. The worst case is set by the series unit.
// Reset empties the selection, edges and costs; weights stay unknown until loaded.
// A finished word waits in the output register while the next word is taken.
`timescale 1ns / 1ps
`default_nettype none

module annealing_independent_set_move_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // vertex[5:0], other_vertex[11:6], weight_value[27:12], temperature[43:28],
    // random_value[59:44]
    input  wire logic [63:0] s_tdata,
    // action[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // accepted[0], run_cost[22:1], best_cost[44:23]
    output logic [47:0]      m_tdata,
    input  wire logic        cfg_wen,
    input  wire logic [aism_pkg::COUNT_BITS-1:0] cfg_wdata
);
    import aism_pkg::*;

    cmd_t cmd;
    sts_t sts;

    aism_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    aism_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata)
    );

endmodule

`default_nettype wire

### tb/tb_annealing_independent_set_move_core.sv
// Testbench for annealing_independent_set_move_core: directed table plus random words,
// each result checked against an in-bench predictor of the selection and cost state.
// Depends on aism_pkg and the core's top level.
`timescale 1ns / 1ps

module tb_annealing_independent_set_move_core;
    import aism_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_wen = 1'b0;
    logic [COUNT_BITS-1:0] cfg_wdata = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    annealing_independent_set_move_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
    );

    typedef struct packed {
        logic        acc;
        logic [21:0] cur;
        logic [21:0] best;
    } move_result_t;

    // predictor state
    logic [15:0] wt [64];
    logic        sel [64];
    logic [63:0] adj [64];
    logic        wt_known [64];
    longint unsigned cost_now, cost_best;
    int unsigned vcount;

    move_result_t result_q [$];
    int errors = 0;
    int idle_pct_s = 0, idle_pct_m = 0;
    int quiet = 0;

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    function automatic longint unsigned neg_exp_series(input longint unsigned f);
        longint unsigned term, pos, neg;
        term = 64'd1 << 32;
        pos = term;
        neg = 0;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * f) >> 32) / k;
            if (k % 2) neg += term; else pos += term;
        end
        return pos - neg;
    endfunction

    function automatic longint unsigned loss_exp_q16(input longint unsigned d,
                                                     input longint unsigned t);
        longint unsigned x, n, r, e1;
        if (t == 0 || d >= 12 * t) return 0;
        x = (d << 32) / t;
        n = x >> 32;
        r = neg_exp_series(x & 64'hFFFF_FFFF);
        e1 = neg_exp_series(64'd1 << 31);
        e1 = (e1 * e1) >> 32;
        for (longint unsigned i = 0; i < n; i++) r = (r * e1) >> 32;
        return r >> 16;
    endfunction

    function automatic move_result_t predict_move(input logic [2:0] act,
                                                  input logic [63:0] d);
        logic [5:0] u, v;
        longint unsigned w, tmp, rnd, add, sub, lim;
        logic u_ok, acc;
        move_result_t r;
        u = d[5:0];
        v = d[11:6];
        w = d[27:12];
        tmp = d[43:28];
        rnd = d[59:44];
        lim = vcount > 64 ? 64 : vcount;
        u_ok = u < lim;
        acc = 1'b0;
        if ((act == ACT_LOAD || act == ACT_MOVE || act == ACT_FLIP) && u_ok) begin
            if (act == ACT_LOAD) begin
                if (sel[u]) cost_now = cost_now - wt[u] + w;
                wt[u] = w[15:0];
                wt_known[u] = 1'b1;
            end else begin
                add = 0;
                sub = 0;
                if (!sel[u]) begin
                    add = wt[u];
                    for (int j = 0; j < 64; j++)
                        if (j != u && sel[j] && adj[u][j]) sub += wt[j];
                end else begin
                    sub = wt[u];
                end
                if (act == ACT_FLIP || add >= sub || loss_exp_q16(sub - add, tmp) > rnd) begin
                    if (!sel[u]) begin
                        for (int j = 0; j < 64; j++)
                            if (j != u && sel[j] && adj[u][j]) sel[j] = 1'b0;
                        sel[u] = 1'b1;
                    end else begin
                        sel[u] = 1'b0;
                    end
                    cost_now = cost_now - sub + add;
                    acc = 1'b1;
                end
            end
        end else if (act == ACT_EDGE && u_ok && v < lim && u != v) begin
            adj[u][v] = 1'b1;
            adj[v][u] = 1'b1;
        end else if (act == ACT_CLEAR) begin
            for (int j = 0; j < 64; j++) sel[j] = 1'b0;
            cost_now = 0;
            cost_best = 0;
        end
        if (cost_now > cost_best) cost_best = cost_now;
        r.acc = acc;
        r.cur = cost_now > 4194303 ? 22'h3FFFFF : cost_now[21:0];
        r.best = cost_best > 4194303 ? 22'h3FFFFF : cost_best[21:0];
        return r;
    endfunction

    function automatic logic [63:0] pack_word(input int u, input int v, input int w,
                                              input int t, input int r);
        logic [63:0] d;
        d = '0;
        d[5:0] = 6'(u);
        d[11:6] = 6'(v);
        d[27:12] = 16'(w);
        d[43:28] = 16'(t);
        d[59:44] = 16'(r);
        return d;
    endfunction

    // a move or a flip may only touch vertices whose weights are known
    function automatic logic safe_word(input logic [2:0] act, input logic [63:0] d);
        logic [5:0] u;
        u = d[5:0];
        if (!(act == ACT_MOVE || act == ACT_FLIP)) return 1'b1;
        if (u >= vcount) return 1'b1;
        if (!wt_known[u]) return 1'b0;
        if (!sel[u])
            for (int j = 0; j < 64; j++)
                if (j != u && sel[j] && adj[u][j] && !wt_known[j]) return 1'b0;
        return 1'b1;
    endfunction

    // valid stays high after a handshake and drops only while the sender idles
    task automatic send_word(input logic [2:0] act, input logic [63:0] d,
                             input logic has_fixed, input move_result_t fixed);
        move_result_t p;
        while (idle_pct_s > 0 && $urandom_range(99) < idle_pct_s) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tuser <= act;
        s_tdata <= d;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p = predict_move(act, d);
        if (has_fixed && p != fixed) begin
            $display("directed row disagrees with predictor");
            errors++;
        end
        result_q.insert(result_q.size(), has_fixed ? fixed : p);
    endtask

    task automatic drain_and_pause();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_count(input int value);
        cfg_wdata <= COUNT_BITS'(value);
        cfg_wen <= 1'b1;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        vcount = value;
    endtask

    // receiver and checker
    always @(posedge aclk) begin
        move_result_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.acc = m_tdata[0];
                got.cur = m_tdata[22:1];
                got.best = m_tdata[44:23];
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected word", got, 0);
                end else begin
                    want = result_q.pop_front();
                    if (got.acc !== want.acc) report_mismatch("accepted", got.acc, want.acc);
                    if (got.cur !== want.cur) report_mismatch("run_cost", got.cur, want.cur);
                    if (got.best !== want.best) report_mismatch("best_cost", got.best, want.best);
                end
            end
            m_tready <= ($urandom_range(99) >= idle_pct_m);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    typedef struct {
        logic [2:0]  act;
        logic [63:0] d;
        logic        fixed;
        move_result_t res;
    } stim_row_t;

    stim_row_t dir_rows [$];

    function automatic stim_row_t row(input logic [2:0] a, input logic [63:0] d,
                                      input logic f, input logic acc,
                                      input int cur, input int best);
        stim_row_t r;
        r.act = a;
        r.d = d;
        r.fixed = f;
        r.res.acc = acc;
        r.res.cur = 22'(cur);
        r.res.best = 22'(best);
        return r;
    endfunction

    function automatic void add_row(input stim_row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    initial begin
        logic [2:0] act;
        logic [63:0] d;
        int n_items, pick;
        move_result_t none;
        for (int j = 0; j < 64; j++) begin
            wt[j] = '0;
            sel[j] = 1'b0;
            adj[j] = '0;
            wt_known[j] = 1'b0;
        end
        cost_now = 0;
        cost_best = 0;
        vcount = 64;
        none = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows
        add_row(row(ACT_CLEAR, '0, 1, 0, 0, 0));
        add_row(row(ACT_LOAD, pack_word(0, 0, 65535, 0, 0), 1, 0, 0, 0));
        add_row(row(ACT_LOAD, pack_word(63, 0, 0, 0, 0), 1, 0, 0, 0));
        add_row(row(ACT_LOAD, pack_word(1, 0, 1000, 0, 0), 1, 0, 0, 0));
        add_row(row(ACT_FLIP, pack_word(0, 0, 0, 0, 0), 1, 1, 65535, 65535));
        add_row(row(ACT_EDGE, pack_word(0, 1, 0, 0, 0), 1, 0, 65535, 65535));
        add_row(row(ACT_EDGE, pack_word(5, 5, 0, 0, 0), 1, 0, 65535, 65535));
        // losing move at high temperature, then moves at minimal and zero temperature
        add_row(row(ACT_MOVE, pack_word(1, 0, 0, 65535, 0), 0, 0, 0, 0));
        add_row(row(ACT_MOVE, pack_word(0, 0, 0, 1, 65535), 0, 0, 0, 0));
        add_row(row(ACT_MOVE, pack_word(0, 0, 0, 0, 0), 0, 0, 0, 0));
        add_row(row(ACT_MOVE, pack_word(63, 0, 0, 1, 0), 0, 0, 0, 0));
        add_row(row(ACT_LOAD, pack_word(0, 0, 12, 0, 0), 0, 0, 0, 0));
        add_row(row(3'd5, pack_word(1, 2, 3, 4, 5), 0, 0, 0, 0));
        add_row(row(3'd7, '1, 0, 0, 0, 0));
        add_row(row(ACT_FLIP, pack_word(1, 0, 0, 0, 0), 0, 0, 0, 0));
        add_row(row(ACT_EDGE, pack_word(63, 0, 0, 0, 0), 0, 0, 0, 0));
        add_row(row(ACT_MOVE, pack_word(0, 0, 0, 200, 30000), 0, 0, 0, 0));
        add_row(row(ACT_CLEAR, '1, 0, 0, 0, 0));
        foreach (dir_rows[i]) begin
            if (dir_rows[i].fixed) send_word(dir_rows[i].act, dir_rows[i].d, 1, dir_rows[i].res);
            else send_word(dir_rows[i].act, dir_rows[i].d, 0, none);
        end
        drain_and_pause();

        // load every weight once so random moves stay in contract
        for (int j = 0; j < 64; j++)
            send_word(ACT_LOAD, pack_word(j, 0, $urandom_range(65535), 0, 0), 0, none);
        drain_and_pause();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin idle_pct_s = 0; idle_pct_m = 0; write_count(64); end
                1: begin idle_pct_s = 87; idle_pct_m = 0; write_count(1); end
                2: begin idle_pct_s = 0; idle_pct_m = 87; write_count(127); end
                3: begin idle_pct_s = 37; idle_pct_m = 37; write_count($urandom_range(2, 63)); end
                default: begin idle_pct_s = 0; idle_pct_m = 0; write_count(0); end
            endcase
            n_items = (ph == 4) ? 30 : 115;
            for (int i = 0; i < n_items; i++) begin
                pick = $urandom_range(99);
                d = {$urandom, $urandom};
                if (vcount > 1 && vcount < 64 && $urandom_range(3) != 0) begin
                    d[5:0] = 6'($urandom_range(vcount - 1));
                    d[11:6] = 6'($urandom_range(vcount - 1));
                end
                if (pick < 10) d[43:28] = 16'($urandom_range(1, 255));
                if (pick < 40) act = ACT_MOVE;
                else if (pick < 55) act = ACT_FLIP;
                else if (pick < 70) act = ACT_EDGE;
                else if (pick < 85) act = ACT_LOAD;
                else if (pick < 90) act = ACT_CLEAR;
                else act = 3'($urandom_range(7));
                if (act == ACT_MOVE && d[43:28] == 0) d[28] = 1'b1;
                if (act == ACT_MOVE && $urandom_range(1))
                    d[43:28] = 16'($urandom_range(100, 65535));
                if (safe_word(act, d)) send_word(act, d, 0, none);
            end
            drain_and_pause();
        end

        if (errors == 0 && result_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
